>>> hw/rtl/r2fft_pkg.sv
`default_nettype none

package r2fft_pkg;

    // Fixed field widths of the register file and of the result port.
    localparam int BIN_W      = 10;
    localparam int LOG2_REG_W = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LOG2_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE     = 1'd1;

    localparam logic [LOG2_REG_W-1:0] LOG2_RESET = 4'd10;

    // Request codes.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // pi/2 in Q60.
    localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic rd;        // read both memory ports and the twiddle table
        logic mul;       // form the four butterfly products
        logic sum;       // combine and round the products
        logic wr_load;   // write a loaded sample
        logic wr_a;      // write the upper butterfly output
        logic wr_b;      // write the lower butterfly output
        logic wr_scale;  // write a word divided by the length
        logic out_cap;   // capture read data into the result register
        logic out_zero;  // present an all-zero, not-ready result
        logic inverse;   // conjugate twiddles
    } t_dp_cmd;

    // Q60 by Q60 product rescaled to Q60 (bits 123:60 of the full product), wrapped to 64 bits.
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // Unsigned 64-bit quotient by restoring long division, one bit per step.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Elaboration-time sine table entry: round(2^tw_frac * sin(pi/2 * m / 2^max_lg)),
    // evaluated with a 15-term Taylor series in Q60.
    function automatic logic [63:0] sine_entry(input int unsigned m,
                                              input int unsigned max_lg,
                                              input int unsigned tw_frac);
        logic [63:0] qtr;
        logic [63:0] mm;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] dv;
        int unsigned sh;
        int unsigned i;
        mm   = 64'(m);
        qtr  = 64'd1 << max_lg;
        t    = (HALF_PI_Q60 >> max_lg) * mm
             + (((HALF_PI_Q60 & (qtr - 64'd1)) * mm) >> max_lg);
        t2   = mul_q60(t, t);
        term = t;
        sum  = t;
        for (i = 1; i <= 14; i++) begin
            dv   = 64'(2 * i) * 64'(2 * i + 1);
            term = udiv64(mul_q60(term, t2), dv);
            if (i[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        sh = 60 - tw_frac;
        return (sum + (64'd1 << (sh - 1))) >> sh;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/radix2_fft_engine_top.sv
// A load request is taken while no result waits; the request that completes a frame of
// n = 2^k points, k > 0, starts the transform, which holds off requests through the
// butterfly passes and, for an inverse transform, the divide-by-n pass. Rate: one request
// per cycle while loading and no result waits. A read of a finished frame passes the
// memory read and S_OUT to the result register; a read of an unfinished frame sets it.
// Reset is synchronous and active low; the sample store is not cleared by reset.
`default_nettype none

module radix2_fft_engine_top
    import r2fft_pkg::*;
#(
    parameter int MAX_LOG2_LENGTH = 10,
    parameter int SAMPLE_BITS     = 16,
    parameter int TWIDDLE_BITS    = 18,
    localparam int WORD_W = SAMPLE_BITS + MAX_LOG2_LENGTH + 1,
    localparam int LGW    = $clog2(MAX_LOG2_LENGTH + 1)
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // Request channel.
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire                          i_mode,
    input  wire signed [SAMPLE_BITS-1:0] i_sample_real,
    input  wire signed [SAMPLE_BITS-1:0] i_sample_imag,
    // Result channel.
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic signed [WORD_W-1:0]     o_result_real,
    output logic signed [WORD_W-1:0]     o_result_imag,
    output logic [BIN_W-1:0]             o_bin_index,
    output logic                         o_last_bin,
    output logic                         o_ready_res,
    // Register writes.
    input  wire                          i_cfg_we,
    input  wire [CFG_IDX_W-1:0]          i_cfg_index,
    input  wire [CFG_DATA_W-1:0]         i_cfg_data
);

    // The controller sequences loads, reads, the butterfly passes (read pair, multiply,
    // round, write upper, write lower) and the optional scaling pass. The datapath
    // owns the sample store, the sine table, the butterfly arithmetic and the
    // result register, which is the only path for results out of the block.
    t_dp_cmd                    w_cmd;
    logic [MAX_LOG2_LENGTH-1:0] w_addr_a;
    logic [MAX_LOG2_LENGTH-1:0] w_addr_b;
    logic [MAX_LOG2_LENGTH:0]   w_twid_k;
    logic [LGW-1:0]             w_scale_lg;
    logic [BIN_W-1:0]           w_bin;
    logic                       w_last;

    r2fft_ctrl #(
        .MAX_LOG2_LENGTH(MAX_LOG2_LENGTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_valid (o_out_valid),
        .o_cmd       (w_cmd),
        .o_addr_a    (w_addr_a),
        .o_addr_b    (w_addr_b),
        .o_twid_k    (w_twid_k),
        .o_scale_lg  (w_scale_lg),
        .o_bin       (w_bin),
        .o_last      (w_last)
    );

    r2fft_datapath #(
        .MAX_LOG2_LENGTH(MAX_LOG2_LENGTH),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .TWIDDLE_BITS   (TWIDDLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_addr_a      (w_addr_a),
        .i_addr_b      (w_addr_b),
        .i_twid_k      (w_twid_k),
        .i_scale_lg    (w_scale_lg),
        .i_sample_real (i_sample_real),
        .i_sample_imag (i_sample_imag),
        .i_bin         (w_bin),
        .i_last        (w_last),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_result_real (o_result_real),
        .o_result_imag (o_result_imag),
        .o_bin_index   (o_bin_index),
        .o_last_bin    (o_last_bin),
        .o_ready_res   (o_ready_res)
    );

endmodule

`default_nettype wire

>>> hw/rtl/r2fft_datapath.sv
`default_nettype none

module r2fft_datapath
    import r2fft_pkg::*;
#(
    parameter int MAX_LOG2_LENGTH = 10,
    parameter int SAMPLE_BITS     = 16,
    parameter int TWIDDLE_BITS    = 18,
    localparam int WORD_W = SAMPLE_BITS + MAX_LOG2_LENGTH + 1,
    localparam int LGW    = $clog2(MAX_LOG2_LENGTH + 1)
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  t_dp_cmd                       i_cmd,
    input  wire [MAX_LOG2_LENGTH-1:0]     i_addr_a,
    input  wire [MAX_LOG2_LENGTH-1:0]     i_addr_b,
    input  wire [MAX_LOG2_LENGTH:0]       i_twid_k,
    input  wire [LGW-1:0]                 i_scale_lg,
    input  wire signed [SAMPLE_BITS-1:0]  i_sample_real,
    input  wire signed [SAMPLE_BITS-1:0]  i_sample_imag,
    input  wire [BIN_W-1:0]               i_bin,
    input  wire                           i_last,
    input  wire                           i_out_stall,
    output logic                          o_out_valid,
    output logic signed [WORD_W-1:0]      o_result_real,
    output logic signed [WORD_W-1:0]      o_result_imag,
    output logic [BIN_W-1:0]              o_bin_index,
    output logic                          o_last_bin,
    output logic                          o_ready_res
);

    localparam int DEPTH  = 1 << MAX_LOG2_LENGTH;
    localparam int QTR    = DEPTH;
    localparam int TW_FRAC = TWIDDLE_BITS - 2;
    localparam int PW     = WORD_W + TWIDDLE_BITS;
    localparam int KW     = MAX_LOG2_LENGTH + 1;
    localparam logic signed [PW:0] RND = (PW + 1)'(1) <<< (TW_FRAC - 1);

    // Quarter-wave sine table.
    logic signed [TWIDDLE_BITS-1:0] w_rom [QTR+1];
    for (genvar m = 0; m <= QTR; m++) begin : g_rom
        localparam logic [TWIDDLE_BITS-1:0] ROM_V =
            TWIDDLE_BITS'(sine_entry(m, MAX_LOG2_LENGTH, TW_FRAC));
        assign w_rom[m] = $signed(ROM_V);
    end

    // Complex word store, real part in the upper half.
    logic [2*WORD_W-1:0] mem [DEPTH];
    logic [2*WORD_W-1:0] r_da;
    logic [2*WORD_W-1:0] r_db;

    logic signed [TWIDDLE_BITS-1:0] r_sn;
    logic signed [TWIDDLE_BITS-1:0] r_cs;
    logic                           r_neg_cs;

    logic signed [PW-1:0] r_p_rr;
    logic signed [PW-1:0] r_p_ii;
    logic signed [PW-1:0] r_p_ri;
    logic signed [PW-1:0] r_p_ir;
    logic [WORD_W-1:0]    r_tr;
    logic [WORD_W-1:0]    r_ti;

    logic                       w_k_hi;
    logic [KW-1:0]              w_sn_addr;
    logic [KW-1:0]              w_cs_addr;
    logic signed [TWIDDLE_BITS-1:0] w_wr;
    logic signed [TWIDDLE_BITS-1:0] w_wi;
    logic signed [WORD_W-1:0]   w_ar;
    logic signed [WORD_W-1:0]   w_ai;
    logic signed [WORD_W-1:0]   w_br;
    logic signed [WORD_W-1:0]   w_bi;
    logic signed [PW:0]         w_dr;
    logic signed [PW:0]         w_di;
    logic signed [PW:0]         w_rr;
    logic signed [PW:0]         w_ri;
    logic signed [WORD_W:0]     w_sc_rnd;
    logic signed [WORD_W:0]     w_sc_r;
    logic signed [WORD_W:0]     w_sc_i;
    logic                       w_we;
    logic [MAX_LOG2_LENGTH-1:0] w_waddr;
    logic [2*WORD_W-1:0]        w_wdata;

    assign w_ar = $signed(r_da[2*WORD_W-1:WORD_W]);
    assign w_ai = $signed(r_da[WORD_W-1:0]);
    assign w_br = $signed(r_db[2*WORD_W-1:WORD_W]);
    assign w_bi = $signed(r_db[WORD_W-1:0]);

    // Angles past a quarter turn fold back onto the table.
    assign w_k_hi    = i_twid_k > KW'(QTR);
    assign w_sn_addr = w_k_hi ? (KW'(0) - i_twid_k) : i_twid_k;
    assign w_cs_addr = w_k_hi ? (i_twid_k - KW'(QTR)) : (KW'(QTR) - i_twid_k);

    assign w_wr = r_neg_cs ? -r_cs : r_cs;
    assign w_wi = i_cmd.inverse ? r_sn : -r_sn;

    assign w_dr = (PW + 1)'(r_p_rr) - (PW + 1)'(r_p_ii);
    assign w_di = (PW + 1)'(r_p_ri) + (PW + 1)'(r_p_ir);
    assign w_rr = (w_dr + RND) >>> TW_FRAC;
    assign w_ri = (w_di + RND) >>> TW_FRAC;

    assign w_sc_rnd = (i_scale_lg == '0) ? '0 : ((WORD_W + 1)'(1) <<< (i_scale_lg - LGW'(1)));
    assign w_sc_r   = ((WORD_W + 1)'(w_ar) + w_sc_rnd) >>> i_scale_lg;
    assign w_sc_i   = ((WORD_W + 1)'(w_ai) + w_sc_rnd) >>> i_scale_lg;

    always_comb begin
        w_we    = i_cmd.wr_load | i_cmd.wr_a | i_cmd.wr_b | i_cmd.wr_scale;
        w_waddr = i_cmd.wr_b ? i_addr_b : i_addr_a;
        w_wdata = {WORD_W'(i_sample_real), WORD_W'(i_sample_imag)};
        if (i_cmd.wr_a) begin
            w_wdata = {r_da[2*WORD_W-1:WORD_W] + r_tr, r_da[WORD_W-1:0] + r_ti};
        end else if (i_cmd.wr_b) begin
            w_wdata = {r_da[2*WORD_W-1:WORD_W] - r_tr, r_da[WORD_W-1:0] - r_ti};
        end else if (i_cmd.wr_scale) begin
            w_wdata = {w_sc_r[WORD_W-1:0], w_sc_i[WORD_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd) begin
            r_da     <= mem[i_addr_a];
            r_db     <= mem[i_addr_b];
            r_sn     <= w_rom[w_sn_addr];
            r_cs     <= w_rom[w_cs_addr];
            r_neg_cs <= w_k_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_p_rr <= PW'(w_br) * PW'(w_wr);
            r_p_ii <= PW'(w_bi) * PW'(w_wi);
            r_p_ri <= PW'(w_br) * PW'(w_wi);
            r_p_ir <= PW'(w_bi) * PW'(w_wr);
        end
        if (i_cmd.sum) begin
            r_tr <= w_rr[WORD_W-1:0];
            r_ti <= w_ri[WORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_cap || i_cmd.out_zero) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_cap) begin
            o_result_real <= w_ar;
            o_result_imag <= w_ai;
            o_bin_index   <= i_bin;
            o_last_bin    <= i_last;
            o_ready_res   <= 1'b1;
        end else if (i_cmd.out_zero) begin
            o_result_real <= '0;
            o_result_imag <= '0;
            o_bin_index   <= '0;
            o_last_bin    <= 1'b0;
            o_ready_res   <= 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/r2fft_ctrl.sv
`default_nettype none

module r2fft_ctrl
    import r2fft_pkg::*;
#(
    parameter int MAX_LOG2_LENGTH = 10,
    localparam int LGW = $clog2(MAX_LOG2_LENGTH + 1)
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_stall,
    input  wire                        i_mode,
    input  wire                        i_cfg_we,
    input  wire [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire [CFG_DATA_W-1:0]       i_cfg_data,
    input  wire                        i_out_valid,
    output t_dp_cmd                    o_cmd,
    output logic [MAX_LOG2_LENGTH-1:0] o_addr_a,
    output logic [MAX_LOG2_LENGTH-1:0] o_addr_b,
    output logic [MAX_LOG2_LENGTH:0]   o_twid_k,
    output logic [LGW-1:0]             o_scale_lg,
    output logic [BIN_W-1:0]           o_bin,
    output logic                       o_last
);

    localparam int AW = MAX_LOG2_LENGTH;
    localparam int KW = MAX_LOG2_LENGTH + 1;
    localparam logic [AW-1:0] ALL1 = {AW{1'b1}};

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_BF_RD  = 4'd1;
    localparam logic [3:0] S_BF_MUL = 4'd2;
    localparam logic [3:0] S_BF_SUM = 4'd3;
    localparam logic [3:0] S_BF_WA  = 4'd4;
    localparam logic [3:0] S_BF_WB  = 4'd5;
    localparam logic [3:0] S_SC_RD  = 4'd6;
    localparam logic [3:0] S_SC_WR  = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0]            r_state;
    logic [LOG2_REG_W-1:0] r_log2_len;
    logic                  r_inv_cfg;
    logic                  r_inv;
    logic [AW-1:0]         r_load_cnt;
    logic [AW-1:0]         r_read_cnt;
    logic                  r_done;
    logic [LGW-1:0]        r_stage;
    logic [AW-1:0]         r_cnt;
    logic [BIN_W-1:0]      r_bin;
    logic                  r_last;

    logic [LGW-1:0] w_lg;
    logic [AW-1:0]  w_mask;
    logic [AW-1:0]  w_rev;
    logic [AW-1:0]  w_load_addr;
    logic [AW-1:0]  w_read_idx;
    logic [AW-1:0]  w_jmask;
    logic [AW-1:0]  w_j;
    logic [AW-1:0]  w_i0;
    logic [AW-1:0]  w_i1;
    logic           w_accept;
    logic           w_bf_last;
    logic           w_stage_last;

    assign w_lg = (int'(r_log2_len) > MAX_LOG2_LENGTH) ? LGW'(MAX_LOG2_LENGTH)
                                                       : LGW'(r_log2_len);
    assign w_mask = ALL1 >> (AW - int'(w_lg));

    always_comb begin
        for (int b = 0; b < AW; b++) begin
            w_rev[b] = r_load_cnt[AW-1-b];
        end
    end

    assign w_load_addr = w_rev >> (AW - int'(w_lg));
    assign w_read_idx  = r_read_cnt & w_mask;

    // Butterfly pair inside the current stage: a zero bit is inserted at the
    // stage position of the butterfly count.
    assign w_jmask = ALL1 >> (AW - int'(r_stage) + 1);
    assign w_j     = r_cnt & w_jmask;
    assign w_i0    = ((r_cnt & ~w_jmask) << 1) | w_j;
    assign w_i1    = w_i0 | (w_jmask + AW'(1));
    assign o_twid_k = KW'(w_j) << (MAX_LOG2_LENGTH + 2 - int'(r_stage));

    assign w_bf_last    = r_cnt == (w_mask >> 1);
    assign w_stage_last = r_stage == w_lg;

    assign o_in_stall = (r_state != S_IDLE) || i_out_valid;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_scale_lg = w_lg;
    assign o_bin      = r_bin;
    assign o_last     = r_last;
    assign o_addr_b   = w_i1;

    always_comb begin
        o_addr_a = w_i0;
        case (r_state)
            S_IDLE: begin
                o_addr_a = (i_mode == MODE_LOAD) ? w_load_addr : w_read_idx;
            end
            S_SC_RD, S_SC_WR: begin
                o_addr_a = r_cnt;
            end
            default: begin
                o_addr_a = w_i0;
            end
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.inverse = r_inv;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_mode == MODE_LOAD) begin
                        o_cmd.wr_load = 1'b1;
                    end else if (r_done) begin
                        o_cmd.rd = 1'b1;
                    end else begin
                        o_cmd.out_zero = 1'b1;
                    end
                end
            end
            S_BF_RD:  o_cmd.rd       = 1'b1;
            S_BF_MUL: o_cmd.mul      = 1'b1;
            S_BF_SUM: o_cmd.sum      = 1'b1;
            S_BF_WA:  o_cmd.wr_a     = 1'b1;
            S_BF_WB:  o_cmd.wr_b     = 1'b1;
            S_SC_RD:  o_cmd.rd       = 1'b1;
            S_SC_WR:  o_cmd.wr_scale = 1'b1;
            S_OUT:    o_cmd.out_cap  = 1'b1;
            default:  o_cmd.out_cap  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_log2_len <= LOG2_RESET;
            r_inv_cfg  <= 1'b0;
            r_inv      <= 1'b0;
            r_load_cnt <= '0;
            r_read_cnt <= '0;
            r_done     <= 1'b0;
            r_stage    <= '0;
            r_cnt      <= '0;
            r_bin      <= '0;
            r_last     <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && i_mode == MODE_LOAD) begin
                        if (r_done) begin
                            r_done     <= 1'b0;
                            r_read_cnt <= '0;
                        end
                        if (r_load_cnt == w_mask) begin
                            r_load_cnt <= '0;
                            if (w_lg == '0) begin
                                r_done     <= 1'b1;
                                r_read_cnt <= '0;
                            end else begin
                                r_state <= S_BF_RD;
                                r_stage <= LGW'(1);
                                r_cnt   <= '0;
                                r_inv   <= r_inv_cfg;
                            end
                        end else begin
                            r_load_cnt <= r_load_cnt + AW'(1);
                        end
                    end else if (w_accept && r_done) begin
                        r_bin      <= BIN_W'(w_read_idx);
                        r_last     <= w_read_idx == w_mask;
                        r_read_cnt <= (w_read_idx == w_mask) ? '0 : w_read_idx + AW'(1);
                        r_state    <= S_OUT;
                    end
                end
                S_OUT:    r_state <= S_IDLE;
                S_BF_RD:  r_state <= S_BF_MUL;
                S_BF_MUL: r_state <= S_BF_SUM;
                S_BF_SUM: r_state <= S_BF_WA;
                S_BF_WA:  r_state <= S_BF_WB;
                S_BF_WB: begin
                    if (!w_bf_last) begin
                        r_cnt   <= r_cnt + AW'(1);
                        r_state <= S_BF_RD;
                    end else if (!w_stage_last) begin
                        r_cnt   <= '0;
                        r_stage <= r_stage + LGW'(1);
                        r_state <= S_BF_RD;
                    end else if (r_inv) begin
                        r_cnt   <= '0;
                        r_state <= S_SC_RD;
                    end else begin
                        r_done     <= 1'b1;
                        r_read_cnt <= '0;
                        r_state    <= S_IDLE;
                    end
                end
                S_SC_RD: r_state <= S_SC_WR;
                S_SC_WR: begin
                    if (r_cnt == w_mask) begin
                        r_done     <= 1'b1;
                        r_read_cnt <= '0;
                        r_state    <= S_IDLE;
                    end else begin
                        r_cnt   <= r_cnt + AW'(1);
                        r_state <= S_SC_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (i_cfg_we && i_cfg_index == CFG_LOG2_LENGTH) begin
                r_log2_len <= i_cfg_data[LOG2_REG_W-1:0];
                r_load_cnt <= '0;
                r_read_cnt <= '0;
                r_done     <= 1'b0;
            end else if (i_cfg_we && i_cfg_index == CFG_INVERSE) begin
                r_inv_cfg <= i_cfg_data[0];
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/r2fft_checker.sv
`default_nettype none

module r2fft_checker
    import r2fft_pkg::*;
#(
    parameter int MAX_LOG2_LENGTH = 10,
    parameter int SAMPLE_BITS     = 16,
    localparam int WORD_W = SAMPLE_BITS + MAX_LOG2_LENGTH + 1
) (
    input wire                     i_clk,
    input wire                     i_rst_n,
    input wire                     o_in_stall,
    input wire                     o_out_valid,
    input wire                     i_out_stall,
    input wire [WORD_W-1:0]        o_result_real,
    input wire [WORD_W-1:0]        o_result_imag,
    input wire [BIN_W-1:0]         o_bin_index,
    input wire                     o_last_bin,
    input wire                     o_ready_res
);

    // A result held by a stall stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A read before the frame is done gives an all-zero result.
    a_not_ready_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ready_res |-> o_result_real == '0 && o_result_imag == '0
                                        && o_bin_index == '0 && !o_last_bin)
        else $error("not-ready result carries data");

    // No new request is taken while a result waits.
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("request taken while a result is pending");

endmodule

bind radix2_fft_engine_top r2fft_checker #(
    .MAX_LOG2_LENGTH(MAX_LOG2_LENGTH),
    .SAMPLE_BITS    (SAMPLE_BITS)
) u_r2fft_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_result_real (o_result_real),
    .o_result_imag (o_result_imag),
    .o_bin_index   (o_bin_index),
    .o_last_bin    (o_last_bin),
    .o_ready_res   (o_ready_res)
);

`default_nettype wire

>>> test/tb_radix2_fft_engine_top.sv
`default_nettype none

// Self-checking bench for the radix-2 FFT engine.
// A driver feeds load and read requests from a queue that the stimulus
// process fills, and a predictor works out the bins that each read request
// must return. A monitor compares every result with the oldest expected bin.
module tb_radix2_fft_engine_top;
    import r2fft_pkg::*;

    localparam int MAX_LG  = 10;
    localparam int MAX_N   = 1 << MAX_LG;
    localparam int WORD_W  = 27;
    localparam int TW_FRAC = 16;
    localparam int STALL_LIMIT = 120000;

    // One request on the input channel.
    typedef struct {
        logic               mode;
        logic signed [15:0] re;
        logic signed [15:0] im;
    } fft_req_t;

    // One bin as the block must present it.
    typedef struct {
        logic signed [WORD_W-1:0] re;
        logic signed [WORD_W-1:0] im;
        logic [BIN_W-1:0]         bin;
        logic                     last;
        logic                     ready;
    } fft_bin_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_mode = MODE_LOAD;
    logic signed [15:0] i_sample_real = '0;
    logic signed [15:0] i_sample_imag = '0;
    logic i_out_stall = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_LOG2_LENGTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    wire o_in_stall;
    wire o_out_valid;
    wire signed [WORD_W-1:0] o_result_real;
    wire signed [WORD_W-1:0] o_result_imag;
    wire [BIN_W-1:0] o_bin_index;
    wire o_last_bin;
    wire o_ready_res;

    radix2_fft_engine_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_sample_real (i_sample_real),
        .i_sample_imag (i_sample_imag),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_real (o_result_real),
        .o_result_imag (o_result_imag),
        .o_bin_index   (o_bin_index),
        .o_last_bin    (o_last_bin),
        .o_ready_res   (o_ready_res),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Requests waiting to be driven, and bins waiting to come out.
    fft_req_t pending_reqs[$];
    fft_bin_t bins_due[$];

    // Shadow of the engine: sample store, counters and the two registers.
    longint sine_q16[MAX_N + 1];
    longint store_re[MAX_N];
    longint store_im[MAX_N];
    int     loads_in_frame;
    int     reads_in_frame;
    bit     frame_ready;
    int     shadow_log2;
    bit     shadow_inverse;

    int errors;
    int n_requests;
    int n_bins_checked;
    int n_frames;

    // Quarter-wave sine table in Q1.16, built from a Taylor series in Q60
    // so that it matches the ROM of the engine bit for bit.
    function automatic longint sine_rounded(input int m);
        logic [63:0]  t;
        logic [63:0]  t2;
        logic [63:0]  term;
        logic [63:0]  acc;
        logic [127:0] p;
        t = (HALF_PI_Q60 >> MAX_LG) * 64'(m)
          + (((HALF_PI_Q60 & 64'(MAX_N - 1)) * 64'(m)) >> MAX_LG);
        p = {64'd0, t} * {64'd0, t};
        t2 = p[123:60];
        term = t;
        acc = t;
        for (int i = 1; i <= 14; i++) begin
            p = {64'd0, term} * {64'd0, t2};
            term = p[123:60] / (64'(2 * i) * 64'(2 * i + 1));
            if (i % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        return longint'((acc + (64'd1 << (59 - TW_FRAC))) >> (60 - TW_FRAC));
    endfunction

    // Round to nearest, ties toward plus infinity, by an arithmetic shift.
    function automatic longint round_div(input longint v, input int sh);
        if (sh == 0) begin
            return v;
        end
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint to_word(input longint v);
        logic signed [WORD_W-1:0] w;
        w = v[WORD_W-1:0];
        return longint'(w);
    endfunction

    function automatic int reverse_bits(input int v, input int nbits);
        int r;
        r = 0;
        for (int i = 0; i < nbits; i++) begin
            r |= ((v >> i) & 1) << (nbits - 1 - i);
        end
        return r;
    endfunction

    function automatic int active_log2();
        return (shadow_log2 > MAX_LG) ? MAX_LG : shadow_log2;
    endfunction

    // In-place butterflies over the bit-reversed frame, then the divide by
    // n for an inverse transform.
    task automatic run_butterflies(input int lg);
        int     n;
        int     half;
        int     i0;
        int     i1;
        longint k;
        longint sn;
        longint cs;
        longint wi;
        longint tr;
        longint ti;
        longint ar;
        longint ai;
        n = 1 << lg;
        for (int s = 1; s <= lg; s++) begin
            half = 1 << (s - 1);
            for (int base = 0; base < n; base += 2 * half) begin
                for (int j = 0; j < half; j++) begin
                    k = longint'(j) << (MAX_LG + 2 - s);
                    if (k <= MAX_N) begin
                        sn = sine_q16[k];
                        cs = sine_q16[MAX_N - k];
                    end else begin
                        sn = sine_q16[2 * MAX_N - k];
                        cs = -sine_q16[k - MAX_N];
                    end
                    wi = shadow_inverse ? sn : -sn;
                    i0 = base + j;
                    i1 = i0 + half;
                    tr = round_div(store_re[i1] * cs - store_im[i1] * wi, TW_FRAC);
                    ti = round_div(store_re[i1] * wi + store_im[i1] * cs, TW_FRAC);
                    ar = store_re[i0];
                    ai = store_im[i0];
                    store_re[i0] = to_word(ar + tr);
                    store_im[i0] = to_word(ai + ti);
                    store_re[i1] = to_word(ar - tr);
                    store_im[i1] = to_word(ai - ti);
                end
            end
        end
        if (shadow_inverse) begin
            for (int i = 0; i < n; i++) begin
                store_re[i] = round_div(store_re[i], lg);
                store_im[i] = round_div(store_im[i], lg);
            end
        end
    endtask

    // Advance the shadow by one accepted request.
    task automatic predict_request(input fft_req_t r);
        int       lg;
        int       n;
        int       addr;
        int       idx;
        fft_bin_t b;
        lg = active_log2();
        n = 1 << lg;
        if (r.mode == MODE_LOAD) begin
            if (frame_ready) begin
                frame_ready = 0;
                reads_in_frame = 0;
                loads_in_frame = 0;
            end
            addr = reverse_bits(loads_in_frame & (n - 1), lg);
            store_re[addr] = longint'(r.re);
            store_im[addr] = longint'(r.im);
            loads_in_frame++;
            if (loads_in_frame >= n) begin
                run_butterflies(lg);
                loads_in_frame = 0;
                reads_in_frame = 0;
                frame_ready = 1;
                n_frames++;
            end
        end else begin
            b = '{default: '0};
            if (frame_ready) begin
                idx = reads_in_frame & (n - 1);
                b.re = store_re[idx][WORD_W-1:0];
                b.im = store_im[idx][WORD_W-1:0];
                b.bin = BIN_W'(idx);
                b.last = (idx == n - 1);
                b.ready = 1'b1;
                reads_in_frame = (idx + 1 == n) ? 0 : idx + 1;
            end
            bins_due.push_back(b);
        end
    endtask

    // Driver: bursts of back-to-back requests separated by random gaps. A
    // stalled request holds its payload and valid until it is taken.
    fft_req_t cur_req;
    int       burst_left = 0;
    int       gap_left = 0;
    bit       next_valid;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (i_in_valid) begin
                predict_request(cur_req);
            end
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_reqs.size() > 0) begin
                cur_req = pending_reqs.pop_front();
                i_mode <= cur_req.mode;
                i_sample_real <= cur_req.re;
                i_sample_imag <= cur_req.im;
                next_valid = 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 48);
                    // Roughly one burst in three runs straight into the next.
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end else begin
                    burst_left--;
                end
            end
            i_in_valid <= next_valid;
        end
    end

    // Result stall: a duty pattern that changes now and then, with spells
    // where the result side never stalls at all.
    int stall_period = 1;
    int stall_duty = 0;
    int stall_phase = 0;

    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) begin
            stall_period = $urandom_range(1, 9);
            stall_duty = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, stall_period);
        end
        stall_phase = (stall_phase + 1) % stall_period;
        i_out_stall <= (stall_phase < stall_duty);
    end

    // Monitor: each taken result against the oldest expected bin.
    fft_bin_t want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (bins_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result re=%0d im=%0d bin=%0d", $time,
                         o_result_real, o_result_imag, o_bin_index);
            end else begin
                want = bins_due.pop_front();
                n_bins_checked++;
                if (o_result_real !== want.re) begin
                    errors++;
                    $display("%0t: result_real expected %0d actual %0d", $time,
                             want.re, o_result_real);
                end
                if (o_result_imag !== want.im) begin
                    errors++;
                    $display("%0t: result_imag expected %0d actual %0d", $time,
                             want.im, o_result_imag);
                end
                if (o_bin_index !== want.bin) begin
                    errors++;
                    $display("%0t: bin_index expected %0d actual %0d", $time,
                             want.bin, o_bin_index);
                end
                if (o_last_bin !== want.last) begin
                    errors++;
                    $display("%0t: last_bin expected %0d actual %0d", $time,
                             want.last, o_last_bin);
                end
                if (o_ready_res !== want.ready) begin
                    errors++;
                    $display("%0t: ready_res expected %0d actual %0d", $time,
                             want.ready, o_ready_res);
                end
            end
        end
    end

    // Watchdog: STALL_LIMIT lies well beyond the time for which the transform of a full
    // frame holds requests off, so a long spell with no handshake at all means a hang.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_radix2_fft_engine_top: done, errors");
            $finish;
        end
    end

    task automatic push_load(input logic signed [15:0] re, input logic signed [15:0] im);
        pending_reqs.push_back('{MODE_LOAD, re, im});
        n_requests++;
    endtask

    task automatic push_reads(input int count);
        for (int i = 0; i < count; i++) begin
            pending_reqs.push_back('{MODE_READ, 16'($urandom), 16'($urandom)});
            n_requests++;
        end
    endtask

    // Wait until every request is taken and every bin has come out, then
    // give a transform started by the last load time to finish.
    task automatic wait_idle();
        int lg;
        int n;
        while (pending_reqs.size() != 0 || i_in_valid || bins_due.size() != 0) begin
            @(negedge i_clk);
        end
        lg = active_log2();
        n = 1 << lg;
        repeat (5 * (n / 2) * lg + 2 * n + 16) @(negedge i_clk);
    endtask

    // Register write, done only while the engine is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        if (idx == CFG_LOG2_LENGTH) begin
            shadow_log2 = value & 15;
            loads_in_frame = 0;
            reads_in_frame = 0;
            frame_ready = 0;
        end else begin
            shadow_inverse = value & 1;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sample values lean on the extremes now and then.
    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return -16'sh8000;
            2: return 16'sh0000;
            3: return -16'sh0001;
            default: return 16'($urandom);
        endcase
    endfunction

    int lg_pick;
    int frames_pick;
    int frame_n;
    int n_loads;

    initial begin
        for (int m = 0; m <= MAX_N; m++) begin
            sine_q16[m] = sine_rounded(m);
        end
        shadow_log2 = LOG2_RESET;
        shadow_inverse = 0;
        loads_in_frame = 0;
        reads_in_frame = 0;
        frame_ready = 0;
        errors = 0;
        n_requests = 0;
        n_bins_checked = 0;
        n_frames = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Reads straight after reset find no finished frame.
        push_reads(2);

        // One-point frames are an identity; reading past the end wraps, and a
        // load after a finished frame starts a new one.
        write_reg(CFG_LOG2_LENGTH, 0);
        write_reg(CFG_INVERSE, 0);
        push_load(16'sh7FFF, -16'sh8000);
        push_reads(2);
        push_load(-16'sh8000, 16'sh7FFF);
        push_reads(1);

        // Two points, forward then inverse with rounding of the halving.
        write_reg(CFG_LOG2_LENGTH, 1);
        push_load(16'sh7FFF, 16'sh7FFF);
        push_load(-16'sh8000, 16'sh7FFF);
        push_reads(3);
        write_reg(CFG_INVERSE, 1);
        push_load(16'sh0001, -16'sh0001);
        push_load(16'sh0000, -16'sh8000);
        push_reads(2);

        // A length code beyond the largest acts as the largest; a length
        // write in the middle of a frame throws the frame away.
        write_reg(CFG_LOG2_LENGTH, 15);
        push_reads(1);
        push_load(16'sh1234, -16'sh1234);
        push_load(16'sh7FFF, 16'sh7FFF);
        write_reg(CFG_LOG2_LENGTH, 2);
        push_reads(1);
        write_reg(CFG_INVERSE, 0);
        for (int i = 0; i < 4; i++) begin
            push_load(-16'sh8000, -16'sh8000);
        end
        push_reads(4);

        // Random part: mostly small lengths, whole frames with random
        // content, and some reads early, aborted frames and late register
        // changes mixed in. The length shrinks when a pick would overrun
        // the request budget of the run.
        while (n_requests < 900) begin
            lg_pick = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 5);
            frames_pick = (lg_pick >= 6) ? 1 : $urandom_range(1, 3);
            while (lg_pick > 0
                   && n_requests + frames_pick * (2 * (1 << lg_pick) + 4) > 920) begin
                lg_pick--;
            end
            write_reg(CFG_LOG2_LENGTH, lg_pick);
            write_reg(CFG_INVERSE, $urandom_range(0, 1));
            frame_n = 1 << lg_pick;
            for (int f = frames_pick; f > 0; f--) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_reads($urandom_range(1, 2));
                end
                if ($urandom_range(0, 9) == 0) begin
                    // Aborted frame: the next length write drops it.
                    n_loads = $urandom_range(0, frame_n - 1);
                    for (int i = 0; i < n_loads; i++) begin
                        push_load(pick_sample(), pick_sample());
                    end
                    break;
                end
                for (int i = 0; i < frame_n; i++) begin
                    if (i == frame_n / 2 && frame_n > 1 && $urandom_range(0, 7) == 0) begin
                        // The direction is taken when the transform runs.
                        write_reg(CFG_INVERSE, $urandom_range(0, 1));
                    end
                    push_load(pick_sample(), pick_sample());
                end
                push_reads($urandom_range(0, frame_n + 2));
            end
        end

        wait_idle();
        repeat (40) @(posedge i_clk);
        $display("Covered %0d requests in %0d transformed frames of 1 to 256 points,",
                 n_requests, n_frames);
        $display("forward and inverse; %0d result bins checked.", n_bins_checked);
        if (errors == 0) begin
            $display("tb_radix2_fft_engine_top: done, clean");
        end else begin
            $display("tb_radix2_fft_engine_top: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
hw/rtl/r2fft_pkg.sv
hw/rtl/r2fft_datapath.sv
hw/rtl/r2fft_ctrl.sv
hw/rtl/radix2_fft_engine_top.sv
hw/rtl/r2fft_checker.sv
test/tb_radix2_fft_engine_top.sv
